// ===== design/tdma_slot_table_mac_top_macros.svh =====
// Assertion macros for the TDMA slot table MAC.
// Used by tdma_slot_table_mac_top; no other dependencies.
`ifndef TDMA_SLOT_TABLE_MAC_TOP_MACROS_SVH
`define TDMA_SLOT_TABLE_MAC_TOP_MACROS_SVH
`ifndef SYNTH
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CHK_NEVER(lbl, clk, rst_n, cond, msg)
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/tstm_pkg.sv =====
// Shared types and constants of the TDMA slot table MAC.
// No dependencies; imported by every module of the block.
package tstm_pkg;

	localparam int ID_W       = 8;
	localparam int REPORTS    = 9;
	localparam int REP_W      = REPORTS * ID_W;
	localparam int SLOT_W     = 4;
	localparam int LISTEN_W   = 5;
	localparam int FRAME_W    = 16;
	localparam int STEP_W     = 4;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 96;

	localparam logic [ID_W-1:0] FREE_ID = 8'hFF;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_DONE
	} state_t;

	// input word payload, last field in the lowest bits
	typedef struct packed {
		logic             have_packet;
		logic [7:0]       random_pick;
		logic [ID_W-1:0]  sender_id;
		logic [ID_W-1:0]  heard_id_last;
		logic [63:0]      heard_ids_low;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	// result word, transmit in bit 0
	typedef struct packed {
		logic              acquire_failed;
		logic              collision;
		logic [SLOT_W-1:0] held_slot;
		logic              slot_held;
		logic [ID_W-1:0]   tx_id_last;
		logic [63:0]       tx_ids_low;
		logic [FRAME_W-1:0] frame_count;
		logic              transmit;
	} result_t;

	typedef struct packed {
		logic              load;
		logic              start;
		logic              walk;
		logic              publish;
		logic [STEP_W-1:0] step;
	} cmd_t;

endpackage

// ===== design/tstm_ctrl.sv =====
// Sequencer of the TDMA slot table MAC: accept, start, per-slot walk, publish.
// Depends on tstm_pkg; drives the command struct of tstm_dpath.
module tstm_ctrl
	import tstm_pkg::*;
#(
	parameter int SLOTS = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_free,
	output cmd_t cmd
);

	localparam int WALK = (SLOTS > REPORTS) ? SLOTS : REPORTS;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WALK - 1);

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				step_q <= '0;
			end else if (cmd.walk) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.step = step_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/tstm_dpath.sv =====
// Datapath of the TDMA slot table MAC: slot table, counters, acquisition
// search, header build and report merge. Depends on tstm_pkg; run by tstm_ctrl.
module tstm_dpath
	import tstm_pkg::*;
#(
	parameter int SLOTS        = 10,
	parameter int LISTEN_SLOTS = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cmd_t            cmd,
	input  item_t           in_item,
	input  logic            in_kind,
	input  logic            cfg_we,
	input  logic [ID_W-1:0] cfg_data,
	output result_t         result
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [LISTEN_W-1:0] LISTEN_MAX = LISTEN_W'(LISTEN_SLOTS);

	// node state
	logic [ID_W-1:0]     own_id_q;
	logic [ID_W-1:0]     owner_q [SLOTS];
	logic [SLOTS-1:0]    heard_q;
	logic [IDX_W-1:0]    sc_q;
	logic [FRAME_W-1:0]  fc_q;
	logic                own_valid_q;
	logic [IDX_W-1:0]    own_idx_q;
	logic                hts_q;
	logic                sent_q;
	logic [LISTEN_W-1:0] listen_q;
	logic                seek_q;

	// current word and work registers
	logic              kind_q;
	logic [REP_W-1:0]  rep_q;
	logic [ID_W-1:0]   sender_q;
	logic [7:0]        pick_q;
	logic              hp_q;
	logic [CNT_W-1:0]  k_q;
	logic [IDX_W-1:0]  rot_q;
	logic [REP_W-1:0]  hdr_q;
	logic              coll_q;
	logic              fail_q;

	logic [SLOTS-1:0]      free_mask;
	logic [CNT_W-1:0]      nfree;
	logic [8+CNT_W-1:0]    prod;
	logic [CNT_W-1:0]      k_new;
	logic                  known;
	logic                  named;
	logic                  coll_now;
	logic [IDX_W-1:0]      sc_next;
	logic [LISTEN_W-1:0]   listen_new;
	logic                  acq;
	logic [ID_W-1:0]       rd_owner;
	logic                  rd_heard;
	logic [ID_W-1:0]       hdr_entry;
	logic                  step_in;
	logic                  rep_step;
	logic                  seek_free;
	logic                  merge_en;
	logic                  take;
	logic                  tx;

	function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
		return (s == LAST_IDX) ? '0 : IDX_W'(s + 1'b1);
	endfunction

	always_comb begin
		nfree = '0;
		known = 1'b0;
		for (int e = 0; e < SLOTS; e++) begin
			free_mask[e] = (owner_q[e] == FREE_ID);
			nfree        = nfree + CNT_W'(free_mask[e]);
			known        = known | (heard_q[e] & (owner_q[e] == sender_q));
		end
		named = 1'b0;
		for (int i = 0; i < REPORTS; i++) begin
			named = named | (rep_q[i*ID_W +: ID_W] == own_id_q);
		end
	end

	// k-th free slot, k = pick * free >> 8
	assign prod     = {{CNT_W{1'b0}}, pick_q} * {8'd0, nfree};
	assign k_new    = prod[8+CNT_W-1:8];
	assign coll_now = sent_q & own_valid_q & known & ~named;

	assign sc_next    = slot_inc(sc_q);
	assign listen_new = (listen_q < LISTEN_MAX) ? LISTEN_W'(listen_q + 1'b1) : listen_q;
	assign acq        = (listen_new == LISTEN_MAX);

	assign rd_owner  = owner_q[rot_q];
	assign rd_heard  = heard_q[rot_q];
	assign hdr_entry = rd_heard ? rd_owner : FREE_ID;

	assign step_in   = (cmd.step < STEP_W'(SLOTS));
	assign rep_step  = (cmd.step < STEP_W'(REPORTS));
	assign seek_free = seek_q & step_in & free_mask[cmd.step[IDX_W-1:0]];
	assign merge_en  = cmd.walk & (kind_q == KIND_FRAME) & rep_step & ~rd_heard
		& ~(own_valid_q & (rot_q == own_idx_q));
	assign take      = cmd.walk & (kind_q == KIND_TICK) & seek_free & (k_q == '0);
	assign tx        = (kind_q == KIND_TICK) & hp_q & own_valid_q & (sc_q == own_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= '0;
			for (int e = 0; e < SLOTS; e++) begin
				owner_q[e] <= FREE_ID;
			end
			heard_q     <= '0;
			sc_q        <= '0;
			fc_q        <= '0;
			own_valid_q <= 1'b0;
			own_idx_q   <= '0;
			hts_q       <= 1'b0;
			sent_q      <= 1'b0;
			listen_q    <= '0;
			seek_q      <= 1'b0;
		end else begin
			if (cmd.start) begin
				if (kind_q == KIND_TICK) begin
					sc_q <= sc_next;
					if (sc_q == LAST_IDX) begin
						fc_q <= fc_q + 1'b1;
					end
					// silent slot just ended
					if (!hts_q) begin
						heard_q[sc_q] <= 1'b0;
					end
					hts_q    <= 1'b0;
					listen_q <= listen_new;
					seek_q   <= acq & (nfree != '0);
				end else begin
					hts_q <= 1'b1;
					if (coll_now) begin
						// held slot equal to the current one takes the sender below
						if (own_idx_q != sc_q) begin
							owner_q[own_idx_q] <= FREE_ID;
						end
						own_valid_q        <= 1'b0;
						own_idx_q          <= '0;
						sent_q             <= 1'b0;
					end else if (own_valid_q) begin
						listen_q <= '0;
					end
					owner_q[sc_q] <= sender_q;
					heard_q[sc_q] <= 1'b1;
					seek_q        <= 1'b0;
				end
			end else if (cmd.walk) begin
				if (merge_en) begin
					owner_q[rot_q] <= rep_q[ID_W-1:0];
				end
				if (take) begin
					own_valid_q <= 1'b1;
					own_idx_q   <= cmd.step[IDX_W-1:0];
					listen_q    <= '0;
					sent_q      <= 1'b0;
					seek_q      <= 1'b0;
				end
			end else if (cmd.publish) begin
				if (tx) begin
					sent_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				own_id_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= in_kind;
			rep_q    <= {in_item.heard_id_last, in_item.heard_ids_low};
			sender_q <= in_item.sender_id;
			pick_q   <= in_item.random_pick;
			hp_q     <= in_item.have_packet;
		end else if (cmd.start) begin
			k_q    <= k_new;
			rot_q  <= (kind_q == KIND_TICK) ? slot_inc(sc_next) : slot_inc(sc_q);
			fail_q <= (kind_q == KIND_TICK) & acq & (nfree == '0);
			coll_q <= (kind_q == KIND_FRAME) & coll_now;
		end else if (cmd.walk) begin
			rot_q <= slot_inc(rot_q);
			if (rep_step) begin
				hdr_q <= {hdr_entry, hdr_q[REP_W-1:ID_W]};
				rep_q <= {{ID_W{1'b0}}, rep_q[REP_W-1:ID_W]};
			end
			if (seek_free && k_q != '0) begin
				k_q <= k_q - 1'b1;
			end
		end
	end

	always_comb begin
		result                = '0;
		result.transmit       = tx;
		result.frame_count    = tx ? fc_q : '0;
		result.tx_ids_low     = tx ? hdr_q[63:0] : '0;
		result.tx_id_last     = tx ? hdr_q[REP_W-1:64] : '0;
		result.slot_held      = own_valid_q;
		result.held_slot      = own_valid_q ? SLOT_W'(own_idx_q) : '0;
		result.collision      = coll_q;
		result.acquire_failed = fail_q;
	end

endmodule

// ===== design/tstm_oreg.sv =====
// Output register of the TDMA slot table MAC: holds one result word for the
// master side. Depends on tstm_pkg.
module tstm_oreg
	import tstm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t din,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t dout,
	output logic    free
);

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign free      = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign dout      = data_q;

endmodule

// ===== design/tdma_slot_table_mac_top.sv =====
// TDMA slot table MAC, top level: sequencer, datapath and output register.
// Depends on tstm_pkg, tstm_ctrl, tstm_dpath, tstm_oreg and the macro header.
//
// Usage:
//  s_axis carries one word per slot tick (tuser 0) or received frame header
//  (tuser 1). m_axis returns exactly one result word per input word, in order.
//  cfg writes own_id; write it only while no word is in flight.
//  Each word is accepted, then a start step (counters, collision check, free
//  count), then a walk that covers every slot and all 9 report entries: one
//  slot per cycle for the free-slot search, one header entry or merged report
//  per cycle through the table read port at rot_q, then a publish step once
//  the output register is free.
//  The output register lets a new word be accepted while a result waits; if
//  m_axis_tready stays low the next result is held in the datapath and
//  s_axis_tready stays low until the output register frees.
//  Reset (arst_n low) clears the slot table to all free, unheard, and the slot,
//  frame and listen counters, the held slot and own_id to zero.
`include "tdma_slot_table_mac_top_macros.svh"
module tdma_slot_table_mac_top
	import tstm_pkg::*;
#(
	parameter int SLOTS        = 10,
	parameter int LISTEN_SLOTS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// heard_ids_low[63:0], heard_id_last[71:64], sender_id[79:72],
	// random_pick[87:80], have_packet[88], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind[0]
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// transmit[0], frame_count[16:1], tx_ids_low[80:17], tx_id_last[88:81],
	// slot_held[89], held_slot[93:90], collision[94], acquire_failed[95]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [ID_W-1:0]       cfg_data
);

	cmd_t    cmd;
	item_t   in_item;
	result_t res;
	result_t out_res;
	logic    out_free;

	assign in_item   = item_t'(s_axis_tdata[ITEM_W-1:0]);
	assign cfg_ready = 1'b1;

	tstm_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.cmd      (cmd)
	);

	tstm_dpath #(
		.SLOTS        (SLOTS),
		.LISTEN_SLOTS (LISTEN_SLOTS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.in_kind  (s_axis_tuser),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.result   (res)
	);

	tstm_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.publish),
		.din       (res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.dout      (out_res),
		.free      (out_free)
	);

	assign m_axis_tdata = out_res;

	`CHK_IMPLY(a_tx_needs_slot, clk, arst_n, m_axis_tvalid && out_res.transmit, out_res.slot_held, "transmit without a held slot")
	`CHK_IMPLY(a_coll_releases, clk, arst_n, m_axis_tvalid && out_res.collision, !out_res.slot_held && !out_res.transmit, "collision left slot held or transmitting")
	`CHK_IMPLY(a_slot_in_range, clk, arst_n, m_axis_tvalid, out_res.held_slot < SLOT_W'(SLOTS), "held slot index out of range")
	`CHK_NEVER(a_publish_blocked, clk, arst_n, cmd.publish && !out_free, "result published into a full output register")

endmodule
